// ===== rtl/tspe_pkg.sv =====
// Shared types, constants and the divide-by-nine digit step for the
// transport stream payload extractor. No dependencies.
`default_nettype none

package tspe_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [7:0] PKT_LEN   = 8'd188;
    localparam logic [7:0] LAST_POS  = 8'd187;
    localparam logic [1:0] ADAPT_AF_PAYLOAD = 2'd3;

    localparam int PTS_W  = 33;
    localparam int PROD_W = 40;
    localparam int PTSU_W = 37;
    localparam int DIV_STAGES = PROD_W / 8;
    localparam int NSTG = DIV_STAGES + 1;

    localparam logic [1:0] CFG_VIDEO_PID  = 2'd0;
    localparam logic [1:0] CFG_AUDIO_PID  = 2'd1;
    localparam logic [1:0] CFG_VIDEO_TYPE = 2'd2;
    localparam logic [1:0] CFG_AUDIO_TYPE = 2'd3;

    typedef struct packed {
        logic             res;
        logic             status;
        logic [7:0]       pbyte;
        logic             ustart;
        logic [7:0]       stype;
        logic             last;
        logic             upd;
        logic [PTS_W-1:0] raw;
    } t_item;

    // one nibble of long division by 9; v < 144
    function automatic logic [7:0] div9_nib(input logic [7:0] v);
        logic [13:0] p;
        logic [3:0]  q;
        logic [7:0]  r;
        p = 14'(v) * 14'd57;
        q = p[12:9];
        r = v - 8'(q) * 8'd9;
        return {q, r[3:0]};
    endfunction

    // {quotient byte, remainder} of ({rem, b}) / 9
    function automatic logic [11:0] div9_byte(input logic [3:0] rem, input logic [7:0] b);
        logic [7:0] s1;
        logic [7:0] s2;
        s1 = div9_nib({rem, b[7:4]});
        s2 = div9_nib({s1[3:0], b[3:0]});
        return {s1[7:4], s2[7:4], s2[3:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tspe_front.sv =====
// Front end: config registers, packet position tracking, header parse and
// word classification. Depends on tspe_pkg.
`default_nettype none

module tspe_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_first,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [12:0]         i_cfg_data,
    output tspe_pkg::t_item          o_item,
    output logic                     o_push
);

    logic [12:0] r_vpid, r_apid;
    logic [7:0]  r_vtype, r_atype;

    logic [7:0]  r_bpos, n_bpos;
    logic [12:0] r_pid, n_pid;
    logic [1:0]  r_adapt, n_adapt;
    logic        r_us, n_us;
    logic        r_acc, n_acc;
    logic [8:0]  r_off, n_off;
    logic [tspe_pkg::PTS_W-1:0] r_raw, n_raw;
    logic [2:0]  r_pts_left, n_pts_left;
    logic        r_fpp, n_fpp;

    logic [7:0]  pos;
    logic        live;
    logic        w_pay;
    logic [9:0]  w_next;
    logic [7:0]  w_stype;
    tspe_pkg::t_item w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpid  <= 13'd256;
            r_apid  <= 13'd257;
            r_vtype <= 8'd1;
            r_atype <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tspe_pkg::CFG_VIDEO_PID:  r_vpid  <= i_cfg_data;
                tspe_pkg::CFG_AUDIO_PID:  r_apid  <= i_cfg_data;
                tspe_pkg::CFG_VIDEO_TYPE: r_vtype <= i_cfg_data[7:0];
                tspe_pkg::CFG_AUDIO_TYPE: r_atype <= i_cfg_data[7:0];
            endcase
        end
    end

    assign w_stype = (r_pid == r_apid) ? r_atype :
                     (r_pid == r_vpid) ? r_vtype : 8'd0;

    always_comb begin
        n_bpos = r_bpos;  n_pid = r_pid;  n_adapt = r_adapt;  n_us = r_us;
        n_acc = r_acc;    n_off = r_off;  n_raw = r_raw;      n_pts_left = r_pts_left;
        n_fpp = r_fpp;
        w_item = '0;
        w_pay  = 1'b0;
        w_next = '0;
        pos  = i_first ? 8'd0 : r_bpos;
        live = i_fire && (i_first || (r_bpos != 8'd0 && r_bpos < tspe_pkg::PKT_LEN));
        if (live) begin
            n_bpos = pos + 8'd1;
            if (pos == 8'd0) begin
                n_acc = (i_byte == tspe_pkg::SYNC_BYTE);
                n_us = 1'b0;  n_fpp = 1'b0;  n_off = '0;  n_pts_left = '0;  n_pid = '0;
            end else if (pos == 8'd1) begin
                n_us  = i_byte[6];
                n_pid = {i_byte[4:0], 8'd0};
            end else if (pos == 8'd2) begin
                n_pid = {r_pid[12:8], i_byte};
                if (n_pid != r_vpid && n_pid != r_apid) n_acc = 1'b0;
            end else if (pos == 8'd3) begin
                n_adapt = i_byte[5:4];
                n_off   = 9'd4;
            end else if (r_acc) begin
                if (r_pts_left != 3'd0) begin
                    n_pts_left = r_pts_left - 3'd1;
                    case (r_pts_left)
                        3'd5:    n_raw = {i_byte[3:1], 30'd0};
                        3'd4:    n_raw[29:22] = i_byte;
                        3'd3:    n_raw[21:15] = i_byte[7:1];
                        3'd2:    n_raw[14:7] = i_byte;
                        default: begin
                            n_raw[6:0] = i_byte[7:1];
                            w_item.upd = 1'b1;
                        end
                    endcase
                end
                if (r_adapt == tspe_pkg::ADAPT_AF_PAYLOAD && pos == 8'd4) begin
                    n_off = 9'd5 + 9'(i_byte);
                    if (n_off > 9'(tspe_pkg::PKT_LEN)) n_acc = 1'b0;
                end else if ({1'b0, pos} < r_off) begin
                    // adaptation field body
                end else if (r_us) begin
                    if (10'(pos) == 10'(r_off) + 10'd8) begin
                        w_next = 10'(r_off) + 10'd9 + 10'(i_byte);
                        if (w_next > 10'(tspe_pkg::PKT_LEN)) begin
                            n_acc = 1'b0;
                        end else begin
                            n_off      = w_next[8:0];
                            n_us       = 1'b0;
                            n_fpp      = 1'b1;
                            n_pts_left = 3'd5;
                        end
                    end
                end else begin
                    w_pay = 1'b1;
                end
            end
            if (pos == tspe_pkg::LAST_POS && n_acc && n_us) n_acc = 1'b0;
            if (w_pay && n_acc) begin
                w_item.res    = 1'b1;
                w_item.pbyte  = i_byte;
                w_item.ustart = r_fpp;
                w_item.stype  = w_stype;
                w_item.last   = (pos == tspe_pkg::LAST_POS);
                n_fpp = 1'b0;
            end else if (pos == tspe_pkg::LAST_POS && !n_acc) begin
                w_item.res    = 1'b1;
                w_item.status = 1'b1;
                w_item.last   = 1'b1;
            end
            w_item.raw = n_raw;
        end
    end

    assign o_item = w_item;
    assign o_push = w_item.res || w_item.upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos <= '0;  r_pid <= '0;  r_adapt <= '0;  r_us <= 1'b0;  r_acc <= 1'b0;
            r_off <= '0;   r_raw <= '0;  r_pts_left <= '0;  r_fpp <= 1'b0;
        end else begin
            r_bpos <= n_bpos;  r_pid <= n_pid;  r_adapt <= n_adapt;  r_us <= n_us;
            r_acc <= n_acc;    r_off <= n_off;  r_raw <= n_raw;
            r_pts_left <= n_pts_left;  r_fpp <= n_fpp;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tspe_fifo.sv =====
// Short word queue between the front end and the back end.
// Depends on tspe_pkg.
`default_nettype none

module tspe_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  tspe_pkg::t_item i_data,
    input  wire logic      i_pop,
    output tspe_pkg::t_item o_data,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tspe_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tspe_back.sv =====
// Back end: PTS x100 / 9 conversion pipeline (one quotient byte per stage)
// and the output register. Depends on tspe_pkg.
`default_nettype none

module tspe_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  tspe_pkg::t_item i_item,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [55:0]     o_data,
    output logic            o_status,
    output logic            o_last
);

    typedef struct packed {
        logic                         v;
        tspe_pkg::t_item              it;
        logic [tspe_pkg::PROD_W-1:0]  y;
        logic [3:0]                   rem;
        logic [tspe_pkg::PROD_W-1:0]  q;
    } t_work;

    t_work r_stg [tspe_pkg::NSTG];
    logic [11:0] w_div [1:tspe_pkg::NSTG-1];
    logic [tspe_pkg::PROD_W-1:0] w_mul;
    logic en;

    logic r_ov;
    logic [tspe_pkg::PTSU_W-1:0] r_pts, w_pts;
    logic [7:0] r_pbyte, r_stype;
    logic r_ustart, r_status, r_last;
    logic [tspe_pkg::PTSU_W-1:0] r_opts;
    t_work w_tail;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_empty;

    assign w_mul = (tspe_pkg::PROD_W'(i_item.raw) << 6) +
                   (tspe_pkg::PROD_W'(i_item.raw) << 5) +
                   (tspe_pkg::PROD_W'(i_item.raw) << 2);

    always_comb begin
        for (int k = 1; k < tspe_pkg::NSTG; k++)
            w_div[k] = tspe_pkg::div9_byte(r_stg[k-1].rem,
                                           r_stg[k-1].y[tspe_pkg::PROD_W-1 -: 8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tspe_pkg::NSTG; k++) r_stg[k].v <= 1'b0;
        end else if (en) begin
            r_stg[0].v   <= o_pop;
            r_stg[0].it  <= i_item;
            r_stg[0].y   <= w_mul;
            r_stg[0].rem <= 4'd0;
            r_stg[0].q   <= '0;
            for (int k = 1; k < tspe_pkg::NSTG; k++) begin
                r_stg[k].v   <= r_stg[k-1].v;
                r_stg[k].it  <= r_stg[k-1].it;
                r_stg[k].y   <= r_stg[k-1].y << 8;
                r_stg[k].rem <= w_div[k][3:0];
                r_stg[k].q   <= {r_stg[k-1].q[tspe_pkg::PROD_W-9:0], w_div[k][11:4]};
            end
        end
    end

    assign w_tail = r_stg[tspe_pkg::NSTG-1];
    assign w_pts  = w_tail.it.upd ? w_tail.q[tspe_pkg::PTSU_W-1:0] : r_pts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_pts <= '0;
        end else if (en) begin
            r_ov <= w_tail.v && w_tail.it.res;
            if (w_tail.v && w_tail.it.upd) r_pts <= w_tail.q[tspe_pkg::PTSU_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pbyte  <= w_tail.it.pbyte;
            r_stype  <= w_tail.it.stype;
            r_ustart <= w_tail.it.ustart;
            r_status <= w_tail.it.status;
            r_last   <= w_tail.it.last;
            r_opts   <= w_tail.it.status ? '0 : w_pts;
        end
    end

    assign o_valid  = r_ov;
    assign o_data   = {2'b00, r_opts, r_stype, r_ustart, r_pbyte};
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

`default_nettype wire

// ===== rtl/ts_pes_payload_extractor.sv =====
// Top level of the transport stream PES payload extractor.
// Depends on tspe_pkg, tspe_front, tspe_fifo, tspe_back.
//
// channel  dir  handshake                word layout
// s        in   i_s_tvalid/o_s_tready    tdata[7:0] byte, tuser packet_first
// m        out  o_m_tvalid/i_m_tready    tdata payload/type/pts, tuser status,
//                                        tlast last_of_packet
// cfg      in   i_cfg_valid/o_cfg_ready  index, data
//
// One byte per cycle sustained while the queue is not full; the front parses in
// the cycle a byte is taken. Output words pass through the six-stage PTS multiply
// and divide-by-nine pipeline after the queue, then the output register.
// Reset is synchronous and clears all control state.
// An output stall freezes the pipeline; the front keeps taking bytes until
// the queue fills.
`default_nettype none

module ts_pes_payload_extractor #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // [7:0] stream_byte
    input  wire logic        i_s_tuser,    // [0] packet_first
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata,    // [7:0] payload_byte, [8] unit_start,
                                           // [16:9] stream_type, [53:17] pts_microseconds
    output logic             o_m_tuser,    // [0] status
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);

    tspe_pkg::t_item w_fitem, w_bitem;
    logic w_push, w_pop, w_full, w_empty, w_fire;

    assign o_s_tready  = !w_full;
    assign o_cfg_ready = 1'b1;
    assign w_fire      = i_s_tvalid && o_s_tready;

    tspe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (i_s_tdata),
        .i_first     (i_s_tuser),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_item      (w_fitem),
        .o_push      (w_push)
    );

    tspe_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fitem),
        .i_pop   (w_pop),
        .o_data  (w_bitem),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tspe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_bitem),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (o_m_tdata),
        .o_status (o_m_tuser),
        .o_last   (o_m_tlast)
    );

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("reject word without last");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 56'd0)
        else $error("reject word carries data");

    a_ustart_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> !o_m_tuser)
        else $error("unit start on reject word");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid && o_s_tready)
        else $error("not idle after reset");

endmodule

`default_nettype wire
